[sv/btss_pkg.sv]
package btss_pkg;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register map of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SECTORS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT2   = 3'd4;

  localparam logic [1:0]  UNIT_ONE    = 2'd1;
  localparam logic [1:0]  UNIT_TWO    = 2'd2;
  localparam logic [6:0]  MAX_BURST   = 7'd64;
  localparam logic [15:0] BLOCK_BYTES = 16'd512;
  localparam logic [4:0]  MAX_HEADS   = 5'd16;
  localparam int          DIV_STEPS   = 16;

  typedef struct packed {
    logic load;      // take the request word
    logic div_step;  // one quotient bit
    logic offs;      // add track offsets, seed sector
    logic advance;   // output word taken, move to next block
  } btss_cmd_t;

  typedef struct packed {
    logic count_zero;  // request on the input carries no blocks
    logic div_last;    // final quotient bit this cycle
    logic last;        // current word is the last of the request
  } btss_sts_t;

endpackage

[sv/btss_ctrl.sv]
module btss_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  btss_pkg::btss_sts_t sts,
  output btss_pkg::btss_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_OFFS = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_EMIT);

  always_comb begin
    state_nxt    = state_r;
    cmd.load     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.offs     = 1'b0;
    cmd.advance  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          // drop an empty request right here
          if (!sts.count_zero) begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_OFFS;
        end
      end
      S_OFFS: begin
        cmd.offs  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_tready) begin
          cmd.advance = 1'b1;
          if (sts.last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/btss_dp.sv]
module btss_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  btss_pkg::btss_cmd_t                 cmd,
  output btss_pkg::btss_sts_t                 sts,
  input  logic                                cfg_we,
  input  logic [btss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [btss_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [btss_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                in_tuser,
  output logic [btss_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tuser,
  output logic                                out_tlast
);

  // configuration registers
  logic [7:0]  spt_r;
  logic [4:0]  heads_r;
  logic [15:0] base_r;
  logic [15:0] unit1_r;
  logic [15:0] unit2_r;

  // request and divider registers
  logic [11:0] span_r;
  logic [15:0] off_r;
  logic [15:0] quo_r;
  logic [11:0] rem_r;
  logic [3:0]  cnt_r;
  logic [15:0] track_r;
  logic [11:0] sector_r;
  logic [15:0] addr_r;
  logic [6:0]  left_r;
  logic        dir_r;

  logic [15:0] req_block;
  logic [1:0]  req_unit;
  logic [6:0]  req_count;
  logic [15:0] req_addr;

  logic [7:0]  spt_eff;
  logic [4:0]  heads_eff;
  logic [12:0] span_prod;
  logic [15:0] unit_off;
  logic [12:0] rem_sh;
  logic        rem_ge;
  logic [12:0] rem_sub;
  logic [11:0] rem_nxt;
  logic [11:0] sector_inc;
  logic        sector_wrap;

  assign req_block = in_tdata[15:0];
  assign req_unit  = in_tdata[17:16];
  assign req_count = in_tdata[24:18];
  assign req_addr  = in_tdata[40:25];

  // zero counts as one, heads clamp at sixteen: span stays within 12 bits
  assign spt_eff   = (spt_r == 8'd0) ? 8'd1 : spt_r;
  assign heads_eff = (heads_r == 5'd0) ? 5'd1 :
                     (heads_r > btss_pkg::MAX_HEADS) ? btss_pkg::MAX_HEADS : heads_r;
  assign span_prod = {5'd0, spt_eff} * {8'd0, heads_eff};

  always_comb begin
    case (req_unit)
      btss_pkg::UNIT_ONE: unit_off = unit1_r;
      btss_pkg::UNIT_TWO: unit_off = unit2_r;
      default:            unit_off = 16'd0;
    endcase
  end

  // restoring division, one quotient bit per cycle
  assign rem_sh  = {rem_r, quo_r[15]};
  assign rem_ge  = (rem_sh >= {1'b0, span_r});
  assign rem_sub = rem_sh - {1'b0, span_r};
  assign rem_nxt = rem_ge ? rem_sub[11:0] : rem_sh[11:0];

  assign sector_inc  = sector_r + 12'd1;
  assign sector_wrap = (sector_inc == span_r);

  assign sts.count_zero = (req_count == 7'd0);
  assign sts.div_last   = (cnt_r == 4'(btss_pkg::DIV_STEPS - 1));
  assign sts.last       = (left_r == 7'd1);

  assign out_tdata = {4'd0, addr_r, sector_r, track_r};
  assign out_tuser = dir_r;
  assign out_tlast = (left_r == 7'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r   <= 8'd17;
      heads_r <= 5'd4;
      base_r  <= 16'd0;
      unit1_r <= 16'd0;
      unit2_r <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        btss_pkg::CFG_SECTORS: spt_r   <= cfg_data[7:0];
        btss_pkg::CFG_HEADS:   heads_r <= cfg_data[4:0];
        btss_pkg::CFG_BASE:    base_r  <= cfg_data;
        btss_pkg::CFG_UNIT1:   unit1_r <= cfg_data;
        btss_pkg::CFG_UNIT2:   unit2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      span_r <= span_prod[11:0];
      off_r  <= base_r + unit_off;
      quo_r  <= req_block;
      rem_r  <= 12'd0;
      cnt_r  <= 4'd0;
      addr_r <= req_addr;
      dir_r  <= in_tuser;
      left_r <= (req_count > btss_pkg::MAX_BURST) ? btss_pkg::MAX_BURST : req_count;
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[14:0], rem_ge};
      cnt_r <= cnt_r + 4'd1;
    end
    if (cmd.offs) begin
      track_r  <= quo_r + off_r;
      sector_r <= rem_r;
    end
    if (cmd.advance) begin
      left_r <= left_r - 7'd1;
      addr_r <= addr_r + btss_pkg::BLOCK_BYTES;
      if (sector_wrap) begin
        sector_r <= 12'd0;
        track_r  <= track_r + 16'd1;
      end else begin
        sector_r <= sector_inc;
      end
    end
  end

endmodule

[sv/block_to_track_sector_sequencer_core.sv]
// Block to track/sector sequencer.
// Input channel (in_*): one transfer request per word; in_tdata carries start
// block, drive unit, block count and buffer address, in_tuser the write flag.
// Output channel (out_*): one drive command per block; out_tdata carries track,
// sector and buffer address, out_tuser the direction, out_tlast marks the last
// command of the request.
// Configuration (cfg_*): write sectors per track, head count and the track
// offsets only while no request is in progress.
// Sequence: a request is taken, then a serial divider splits the 16-bit start
// block by the track span, the offsets are added to the quotient, and out_tvalid
// rises with the first command. Later commands follow one per cycle while
// out_tready is high; the next request is taken the cycle after the last
// command is taken.
// A request with a zero block count is taken and dropped; it yields no commands.
// Counts above 64 are cut to 64.
// When out_tready is low the current command holds on the output.
// Reset: synchronous, active low; loads the default geometry (17 sectors,
// 4 heads, zero offsets) and returns to idle with in_tready high.
module block_to_track_sector_sequencer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [15:0] start_block, [17:16] drive_unit, [24:18] block_count,
  // [40:25] start_address, [47:41] zero
  input  logic [btss_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] write_request
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [15:0] track, [27:16] sector, [43:28] buffer_address, [47:44] zero
  output logic [btss_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] write_flag
  output logic                            out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [btss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [btss_pkg::CFG_DATA_W-1:0] cfg_data
);

  btss_pkg::btss_cmd_t cmd;
  btss_pkg::btss_sts_t sts;

  btss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  btss_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while a command is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tdata[24:18] != 7'd0)) |=> !in_tready)
    else $error("nonempty request did not start work");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && !out_tvalid))
    else $error("not idle after last command");

  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> out_tvalid)
    else $error("burst stopped before last command");
`endif

endmodule
